@@ design/brle_pkg.sv @@
// ----------------------------------------------------------------------------
// brle_pkg
// Shared constants and controller/datapath types of the byte run-length
// encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

  localparam int unsigned LIT_CHUNK  = 128;  // literal bytes per header
  localparam int unsigned RUN_CHUNK  = 130;  // longest run per header
  localparam int unsigned RUN_MIN    = 3;    // shortest run worth a header
  localparam int unsigned LIT_ADDR_W = $clog2(LIT_CHUNK);
  localparam int unsigned LIT_CNT_W  = $clog2(LIT_CHUNK + 1);
  localparam int unsigned RUN_LEN_W  = $clog2(RUN_CHUNK + 1);
  localparam logic [7:0]  RUN_FLAG   = 8'h80;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CLOSE,
    ST_LIT_ADD,
    ST_FL_HDR,
    ST_FL_DATA,
    ST_RUN_HDR,
    ST_RUN_VAL,
    ST_NEW_RUN,
    ST_END_FL,
    ST_PACK_FLUSH,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,        // latch the input byte and end flag
    OP_RUN_INC,     // extend the current run
    OP_LIT_ADD,     // move one run byte into the literal memory
    OP_LIT_HDR,     // emit literal header, start memory read
    OP_LIT_DATA,    // emit one literal from memory
    OP_RUN_HDR,     // emit run header
    OP_RUN_VAL,     // emit run value, close run
    OP_NEW_RUN,     // start a run with the latched byte
    OP_PACK_FLUSH,  // move a partly filled word to the hold stage
    OP_FINISH       // release the held word as last of the item
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic stall;      // command cannot complete this cycle
    logic run_match;  // latched byte continues the current run
    logic run_full;   // run has reached a full chunk
    logic run_long;   // run is long enough for a run header
    logic run_zero;   // no run open
    logic lit_empty;
    logic lit_full;   // next literal fills the chunk
    logic lit_last;   // memory data is the last literal to send
    logic blk_end;    // latched item ends the block
  } status_t;

endpackage

@@ design/brle_ctrl.sv @@
// ----------------------------------------------------------------------------
// brle_ctrl
// Sequencer of the encoder: walks one input byte through run tracking,
// literal collection, chunk flushes and result release.
// ----------------------------------------------------------------------------
module brle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output brle_pkg::cmd_t    cmd,
  input  brle_pkg::status_t st
);

  brle_pkg::ctl_state_t state_r, state_nxt, next;
  brle_pkg::ctl_state_t ret_r, ret_nxt, ret_new;
  logic                 phase_r, phase_nxt, phase_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brle_pkg::ST_IDLE;
      ret_r   <= brle_pkg::ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    next      = state_r;
    ret_new   = ret_r;
    phase_new = phase_r;
    cmd.op    = brle_pkg::OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      brle_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = brle_pkg::OP_LOAD;
          phase_new = 1'b0;
          next      = brle_pkg::ST_DECIDE;
        end
      end
      brle_pkg::ST_DECIDE: begin
        if (st.run_match && !st.run_full) begin
          cmd.op = brle_pkg::OP_RUN_INC;
          if (st.blk_end) begin
            phase_new = 1'b1;
            next      = brle_pkg::ST_CLOSE;
          end else begin
            next = brle_pkg::ST_FINISH;
          end
        end else begin
          next = brle_pkg::ST_CLOSE;
        end
      end
      brle_pkg::ST_CLOSE: begin
        if (st.run_long) begin
          ret_new = brle_pkg::ST_RUN_HDR;
          next    = brle_pkg::ST_FL_HDR;
        end else begin
          next = brle_pkg::ST_LIT_ADD;
        end
      end
      brle_pkg::ST_LIT_ADD: begin
        if (st.run_zero) begin
          next = phase_r ? brle_pkg::ST_END_FL : brle_pkg::ST_NEW_RUN;
        end else begin
          cmd.op = brle_pkg::OP_LIT_ADD;
          if (st.lit_full) begin
            ret_new = brle_pkg::ST_LIT_ADD;
            next    = brle_pkg::ST_FL_HDR;
          end
        end
      end
      brle_pkg::ST_FL_HDR: begin
        if (st.lit_empty) begin
          next = ret_r;
        end else begin
          cmd.op = brle_pkg::OP_LIT_HDR;
          next   = brle_pkg::ST_FL_DATA;
        end
      end
      brle_pkg::ST_FL_DATA: begin
        cmd.op = brle_pkg::OP_LIT_DATA;
        if (st.lit_last) begin
          next = ret_r;
        end
      end
      brle_pkg::ST_RUN_HDR: begin
        cmd.op = brle_pkg::OP_RUN_HDR;
        next   = brle_pkg::ST_RUN_VAL;
      end
      brle_pkg::ST_RUN_VAL: begin
        cmd.op = brle_pkg::OP_RUN_VAL;
        next   = phase_r ? brle_pkg::ST_END_FL : brle_pkg::ST_NEW_RUN;
      end
      brle_pkg::ST_NEW_RUN: begin
        cmd.op = brle_pkg::OP_NEW_RUN;
        if (st.blk_end) begin
          phase_new = 1'b1;
          next      = brle_pkg::ST_CLOSE;
        end else begin
          next = brle_pkg::ST_FINISH;
        end
      end
      brle_pkg::ST_END_FL: begin
        ret_new = brle_pkg::ST_PACK_FLUSH;
        next    = brle_pkg::ST_FL_HDR;
      end
      brle_pkg::ST_PACK_FLUSH: begin
        cmd.op = brle_pkg::OP_PACK_FLUSH;
        next   = brle_pkg::ST_FINISH;
      end
      brle_pkg::ST_FINISH: begin
        cmd.op = brle_pkg::OP_FINISH;
        next   = brle_pkg::ST_IDLE;
      end
      default: begin
        next = brle_pkg::ST_IDLE;
      end
    endcase
  end

  // hold everything while the datapath waits on the output side
  always_comb begin
    state_nxt = st.stall ? state_r : next;
    ret_nxt   = st.stall ? ret_r   : ret_new;
    phase_nxt = st.stall ? phase_r : phase_new;
  end

endmodule

@@ design/brle_dp.sv @@
// ----------------------------------------------------------------------------
// brle_dp
// Datapath of the encoder: run registers, literal memory, byte packer,
// hold stage and output register.
// ----------------------------------------------------------------------------
module brle_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  brle_pkg::cmd_t     cmd,
  output brle_pkg::status_t  st,
  input  logic [7:0]         in_byte,
  input  logic               in_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_lanes,
  output logic [2:0]         out_used,
  output logic               out_last_item,
  output logic               out_eos
);

  localparam int unsigned AW = brle_pkg::LIT_ADDR_W;
  localparam int unsigned CW = brle_pkg::LIT_CNT_W;
  localparam int unsigned RW = brle_pkg::RUN_LEN_W;

  // item and run state
  logic [7:0]    byte_r, byte_nxt;
  logic          end_r, end_nxt;
  logic [7:0]    run_val_r, run_val_nxt;
  logic [RW-1:0] run_len_r, run_len_nxt;

  // literal memory
  logic [7:0]    lit_mem [brle_pkg::LIT_CHUNK];
  logic [7:0]    mem_q_r;
  logic [CW-1:0] lit_cnt_r, lit_cnt_nxt;
  logic [AW-1:0] lit_idx_r, lit_idx_nxt;
  logic [AW-1:0] rd_addr;
  logic          lit_we;

  // packer, hold stage, output register
  logic [23:0]   pk_buf_r, pk_buf_nxt;
  logic [1:0]    pk_cnt_r, pk_cnt_nxt;
  logic          hold_vld_r, hold_vld_nxt;
  logic [31:0]   hold_data_r, hold_data_nxt;
  logic [2:0]    hold_used_r, hold_used_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic [2:0]    out_used_r, out_used_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_eos_r, out_eos_nxt;

  logic          emit;
  logic [7:0]    emit_byte;
  logic [7:0]    run_hdr;
  logic          need_push;
  logic          out_free;
  logic          go;
  logic          push;

  assign out_free = !out_vld_r || out_ready;

  always_comb begin
    run_hdr = brle_pkg::RUN_FLAG |
              {1'b0, 7'(run_len_r - RW'(brle_pkg::RUN_MIN))};
    emit      = 1'b0;
    emit_byte = 8'h00;
    case (cmd.op)
      brle_pkg::OP_LIT_HDR: begin
        emit      = 1'b1;
        emit_byte = 8'(lit_cnt_r - CW'(1));
      end
      brle_pkg::OP_LIT_DATA: begin
        emit      = 1'b1;
        emit_byte = mem_q_r;
      end
      brle_pkg::OP_RUN_HDR: begin
        emit      = 1'b1;
        emit_byte = run_hdr;
      end
      brle_pkg::OP_RUN_VAL: begin
        emit      = 1'b1;
        emit_byte = run_val_r;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // a completed word or OP_FINISH sends the held word to the output slot
  always_comb begin
    need_push = hold_vld_r &&
                ((emit && pk_cnt_r == 2'd3) ||
                 (cmd.op == brle_pkg::OP_PACK_FLUSH && pk_cnt_r != 2'd0) ||
                 (cmd.op == brle_pkg::OP_FINISH));
    go        = !(need_push && !out_free);
    push      = need_push && out_free;
  end

  always_comb begin
    st.stall     = !go;
    st.run_match = (run_len_r != '0) && (byte_r == run_val_r);
    st.run_full  = run_len_r >= RW'(brle_pkg::RUN_CHUNK);
    st.run_long  = run_len_r >= RW'(brle_pkg::RUN_MIN);
    st.run_zero  = run_len_r == '0;
    st.lit_empty = lit_cnt_r == '0;
    st.lit_full  = lit_cnt_r == CW'(brle_pkg::LIT_CHUNK - 1);
    st.lit_last  = lit_idx_r == AW'(lit_cnt_r - CW'(1));
    st.blk_end   = end_r;
  end

  // item, run and literal bookkeeping
  always_comb begin
    byte_nxt    = byte_r;
    end_nxt     = end_r;
    run_val_nxt = run_val_r;
    run_len_nxt = run_len_r;
    lit_cnt_nxt = lit_cnt_r;
    lit_idx_nxt = lit_idx_r;
    lit_we      = 1'b0;
    rd_addr     = '0;
    case (cmd.op)
      brle_pkg::OP_LOAD: begin
        byte_nxt = in_byte;
        end_nxt  = in_end;
      end
      brle_pkg::OP_RUN_INC: begin
        run_len_nxt = run_len_r + RW'(1);
      end
      brle_pkg::OP_LIT_ADD: begin
        lit_we      = 1'b1;
        lit_cnt_nxt = lit_cnt_r + CW'(1);
        run_len_nxt = run_len_r - RW'(1);
      end
      brle_pkg::OP_LIT_HDR: begin
        if (go) begin
          lit_idx_nxt = '0;
        end
      end
      brle_pkg::OP_LIT_DATA: begin
        if (go) begin
          rd_addr     = lit_idx_r + AW'(1);
          lit_idx_nxt = lit_idx_r + AW'(1);
          if (st.lit_last) begin
            lit_cnt_nxt = '0;
          end
        end else begin
          rd_addr = lit_idx_r;
        end
      end
      brle_pkg::OP_RUN_VAL: begin
        if (go) begin
          run_len_nxt = '0;
        end
      end
      brle_pkg::OP_NEW_RUN: begin
        run_val_nxt = byte_r;
        run_len_nxt = RW'(1);
      end
      brle_pkg::OP_PACK_FLUSH: begin
        if (go) begin
          run_val_nxt = '0;
          run_len_nxt = '0;
          lit_cnt_nxt = '0;
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // packer, hold stage and output register
  always_comb begin
    pk_buf_nxt    = pk_buf_r;
    pk_cnt_nxt    = pk_cnt_r;
    hold_vld_nxt  = hold_vld_r;
    hold_data_nxt = hold_data_r;
    hold_used_nxt = hold_used_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    out_data_nxt  = out_data_r;
    out_used_nxt  = out_used_r;
    out_last_nxt  = out_last_r;
    out_eos_nxt   = out_eos_r;
    if (push) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = hold_data_r;
      out_used_nxt = hold_used_r;
      out_last_nxt = (cmd.op == brle_pkg::OP_FINISH);
      out_eos_nxt  = (cmd.op == brle_pkg::OP_FINISH) && end_r;
    end
    if (go) begin
      if (emit) begin
        if (pk_cnt_r == 2'd3) begin
          hold_vld_nxt  = 1'b1;
          hold_data_nxt = {emit_byte, pk_buf_r};
          hold_used_nxt = 3'd4;
          pk_buf_nxt    = '0;
          pk_cnt_nxt    = '0;
        end else begin
          pk_buf_nxt = pk_buf_r | (24'(emit_byte) << {pk_cnt_r, 3'b000});
          pk_cnt_nxt = pk_cnt_r + 2'd1;
        end
      end else if (cmd.op == brle_pkg::OP_PACK_FLUSH && pk_cnt_r != 2'd0) begin
        hold_vld_nxt  = 1'b1;
        hold_data_nxt = {8'h00, pk_buf_r};
        hold_used_nxt = {1'b0, pk_cnt_r};
        pk_buf_nxt    = '0;
        pk_cnt_nxt    = '0;
      end else if (cmd.op == brle_pkg::OP_FINISH) begin
        hold_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lit_we) begin
      lit_mem[lit_cnt_r[AW-1:0]] <= run_val_r;
    end
    mem_q_r <= lit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    end_r       <= end_nxt;
    hold_data_r <= hold_data_nxt;
    hold_used_r <= hold_used_nxt;
    out_data_r  <= out_data_nxt;
    out_used_r  <= out_used_nxt;
    out_last_r  <= out_last_nxt;
    out_eos_r   <= out_eos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_val_r  <= '0;
      run_len_r  <= '0;
      lit_cnt_r  <= '0;
      lit_idx_r  <= '0;
      pk_buf_r   <= '0;
      pk_cnt_r   <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      run_val_r  <= run_val_nxt;
      run_len_r  <= run_len_nxt;
      lit_cnt_r  <= lit_cnt_nxt;
      lit_idx_r  <= lit_idx_nxt;
      pk_buf_r   <= pk_buf_nxt;
      pk_cnt_r   <= pk_cnt_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_lanes     = out_data_r;
  assign out_used      = out_used_r;
  assign out_last_item = out_last_r;
  assign out_eos       = out_eos_r;

  a_lit_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lit_cnt_r <= CW'(brle_pkg::LIT_CHUNK))
    else $error("literal count past chunk size");

  a_run_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_len_r <= RW'(brle_pkg::RUN_CHUNK))
    else $error("run length past chunk size");

  a_hold_used: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> (hold_used_r != 3'd0 && hold_used_r <= 3'd4))
    else $error("held word has no valid lanes");

  a_eos_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (push && cmd.op == brle_pkg::OP_FINISH && end_r) |->
      (pk_cnt_r == 2'd0 && lit_cnt_r == '0 && run_len_r == '0))
    else $error("block closed with bytes still pending");

endmodule

@@ design/byte_run_length_encoder.sv @@
// ----------------------------------------------------------------------------
// byte_run_length_encoder
// Run-length encoder for byte blocks: runs of three or more equal bytes as
// a run header plus value, everything else as counted literal chunks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one raw byte per transfer, in_tlast on the final
//   byte of a block. Output channel out_*: encoded bytes packed four to a
//   transfer, lane 0 first, with the lane count beside them; out_tuser
//   marks the final transfer caused by an input byte, out_tlast the final
//   transfer of the block. Unused lanes read as zero.
//   Timing: a byte that emits nothing is handled fastest when it extends
//   a run and slowest when a run of two moves into the literal memory.
//   Every encoded byte is emitted in a step of its own; a literal flush
//   sends its header and then its literals, paced by the single read port
//   of the literal memory. A block end adds the close of the open run and
//   the final flush. The last word of an item is held back until the item's
//   closing cycle and appears on the output as in_tready rises again.
//   Reset clears all run, literal and packer state; no clearing pass runs.
//   If the receiver stalls, the output register holds its word, the hold
//   stage keeps the next, and the encoder waits when a further word has to
//   move; in_tready stays low until the current byte is fully handled.
// ----------------------------------------------------------------------------
module byte_run_length_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // block_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] lane_0, [15:8] lane_1, [23:16] lane_2,
                                  // [31:24] lane_3, [34:32] lanes_used, zero above
  output logic        out_tuser,  // [0] last_of_item
  output logic        out_tlast   // end_of_stream
);

  brle_pkg::cmd_t    cmd;
  brle_pkg::status_t st;
  logic [31:0]       lanes;
  logic [2:0]        used;

  brle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .st        (st)
  );

  brle_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_byte       (in_tdata),
    .in_end        (in_tlast),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_lanes     (lanes),
    .out_used      (used),
    .out_last_item (out_tuser),
    .out_eos       (out_tlast)
  );

  assign out_tdata = {5'b00000, used, lanes};

endmodule
